### hdl/sppc_pkg.sv
// Shared types, status codes and CRC/bit helpers for the sensor packet parser.
`timescale 1ns / 1ps

package sppc_pkg;

    // Result status codes.
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_VERSION   = 3'd2;
    localparam logic [2:0] ST_UNKNOWN_CHAN  = 3'd3;
    localparam logic [2:0] ST_BAD_FAULTS    = 3'd4;
    localparam logic [2:0] ST_LEN_MISMATCH  = 3'd5;
    localparam logic [2:0] ST_BAD_CRC       = 3'd6;

    // Configuration register indexes (address bit 2 selects the register).
    localparam logic REG_EXPECTED_VERSION = 1'b0;
    localparam logic REG_KNOWN_CHANNELS   = 1'b1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [5:0]  COUNT_MAX = 6'd63;
    localparam logic [5:0]  MIN_PACKET_BYTES = 6'd14;
    localparam logic [6:0]  FRAME_OVERHEAD = 7'd14;

    typedef struct packed {
        logic accept;       // a packet byte is taken this cycle
        logic load_status;  // load the status result into the output register
        logic load_next;    // load the next channel result
        logic restart;      // return the packet state to its idle values
    } sppc_cmd_t;

    typedef struct packed {
        logic more;         // channel results are still to be sent
        logic last;         // the result now in the output register is the last
    } sppc_stat_t;

    // CRC-16/CCITT-FALSE update for one byte, MSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Bit number of the lowest set bit, zero for an empty mask.
    function automatic logic [3:0] lowest_bit(input logic [15:0] mask);
        logic [3:0] idx;
        idx = 4'd0;
        for (int k = 15; k >= 0; k--)
        begin
            if (mask[k])
                idx = 4'(k);
        end
        return idx;
    endfunction

    function automatic logic [4:0] count_ones(input logic [15:0] mask);
        logic [4:0] n;
        n = 5'd0;
        for (int k = 0; k < 16; k++)
        begin
            n = n + {4'd0, mask[k]};
        end
        return n;
    endfunction

endpackage

### hdl/sppc_byte_if.sv
// Request channel that carries packet bytes into the parser.
`timescale 1ns / 1ps

interface sppc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_packet;

    modport source (output valid, output data_byte, output end_of_packet, input ready);
    modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface

### hdl/sppc_result_if.sv
// Request channel that carries status and channel results out of the parser.
`timescale 1ns / 1ps

interface sppc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  node_id;
    logic [15:0] firmware_rev;
    logic [15:0] seq;
    logic [15:0] battery_level;
    logic [15:0] chan_present;
    logic [15:0] chan_faults;
    logic        is_channel;
    logic [3:0]  channel_index;
    logic [15:0] channel_value;
    logic        last;

    modport source (
        output valid, output status, output node_id, output firmware_rev, output seq,
        output battery_level, output chan_present, output chan_faults, output is_channel,
        output channel_index, output channel_value, output last, input ready
    );
    modport sink (
        input valid, input status, input node_id, input firmware_rev, input seq,
        input battery_level, input chan_present, input chan_faults, input is_channel,
        input channel_index, input channel_value, input last, output ready
    );
endinterface

### hdl/sppc_ctrl.sv
// Controller state machine: byte intake, status check and result burst.
`timescale 1ns / 1ps

module sppc_ctrl
    import sppc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_eop,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output sppc_cmd_t  cmd,
    input  sppc_stat_t stat
);

    localparam logic [1:0] S_RECV  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_OUT   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready  = (state_reg == S_RECV);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_RECV:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (in_eop)
                        state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.load_status = 1'b1;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (stat.more)
                    begin
                        cmd.load_next = 1'b1;
                    end
                    else
                    begin
                        cmd.restart = 1'b1;
                        state_next  = S_RECV;
                    end
                end
            end
            default:
            begin
                state_next = S_RECV;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_RECV;
        else
            state_reg <= state_next;
    end

    a_sides_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("byte intake and result output active together");

    a_eop_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_eop) |=> (state_reg == S_CHECK))
        else $error("end of packet did not start the check");

    a_check_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |=> out_valid)
        else $error("status result not presented after the check");

    a_last_matches_more: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (stat.last != stat.more))
        else $error("last flag disagrees with pending channel results");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && stat.last) |=> in_ready)
        else $error("burst did not end after the last result");

endmodule

### hdl/sppc_dpath.sv
// Datapath: header capture, CRC, channel store, status check and result register.
`timescale 1ns / 1ps

module sppc_dpath
    import sppc_pkg::*;
#(
    parameter int MAX_CHANNELS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  expected_version,
    input  logic [15:0] known_channels,
    input  sppc_cmd_t   cmd,
    output sppc_stat_t  stat,
    output logic [2:0]  status,
    output logic [7:0]  node_id,
    output logic [15:0] firmware_rev,
    output logic [15:0] seq,
    output logic [15:0] battery_level,
    output logic [15:0] chan_present,
    output logic [15:0] chan_faults,
    output logic        is_channel,
    output logic [3:0]  channel_index,
    output logic [15:0] channel_value,
    output logic        last
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [15:0] LIMIT_MASK = 16'((33'd1 << MAX_CHANNELS) - 33'd1);

    // Packet state
    logic [5:0]  count_reg,  count_next;
    logic [15:0] crc_reg,    crc_next;
    logic [15:0] held_reg,   held_next;
    logic [7:0]  low_reg,    low_next;
    logic [15:0] remain_reg, remain_next;

    // Header fields
    logic [7:0]  version_reg, version_next;
    logic [7:0]  node_reg,    node_next;
    logic [15:0] fw_reg,      fw_next;
    logic [15:0] seq_reg,     seq_next;
    logic [15:0] batt_reg,    batt_next;
    logic [15:0] chan_reg,    chan_next;
    logic [15:0] fault_reg,   fault_next;

    // Channel store, written once per payload word
    logic [15:0]      store_reg [MAX_CHANNELS];
    logic             store_we;
    logic [IDX_W-1:0] store_waddr;
    logic [3:0]       fill_bit;

    // Result register
    logic [15:0] emit_reg,    emit_next;
    logic [2:0]  o_status_reg, o_status_next;
    logic        o_blank_reg,  o_blank_next;
    logic        o_is_ch_reg,  o_is_ch_next;
    logic [3:0]  o_idx_reg,    o_idx_next;
    logic [15:0] o_value_reg,  o_value_next;
    logic        o_last_reg,   o_last_next;

    // Status check
    logic [4:0]  present;
    logic [6:0]  expected_len;
    logic [15:0] known;
    logic [2:0]  check_status;
    logic [3:0]  emit_bit;

    assign fill_bit = lowest_bit(remain_reg);
    assign emit_bit = lowest_bit(emit_reg);

    always_comb
    begin
        present      = count_ones(chan_reg);
        expected_len = FRAME_OVERHEAD + {1'b0, present, 1'b0};
        known        = known_channels & LIMIT_MASK;
        priority if (count_reg < MIN_PACKET_BYTES)
            check_status = ST_TOO_SHORT;
        else if (version_reg != expected_version)
            check_status = ST_BAD_VERSION;
        else if ((chan_reg & ~known) != 16'd0)
            check_status = ST_UNKNOWN_CHAN;
        else if ((fault_reg & ~chan_reg) != 16'd0)
            check_status = ST_BAD_FAULTS;
        else if ({1'b0, count_reg} != expected_len)
            check_status = ST_LEN_MISMATCH;
        else if (crc_reg != held_reg)
            check_status = ST_BAD_CRC;
        else
            check_status = ST_OK;
    end

    always_comb
    begin
        count_next   = count_reg;
        crc_next     = crc_reg;
        held_next    = held_reg;
        low_next     = low_reg;
        remain_next  = remain_reg;
        version_next = version_reg;
        node_next    = node_reg;
        fw_next      = fw_reg;
        seq_next     = seq_reg;
        batt_next    = batt_reg;
        chan_next    = chan_reg;
        fault_next   = fault_reg;
        store_we     = 1'b0;
        store_waddr  = fill_bit[IDX_W-1:0];

        if (cmd.accept)
        begin
            // The CRC trails the input by two bytes so the trailer stays out of it.
            if (count_reg >= 6'd2)
                crc_next = crc_feed(crc_reg, held_reg[7:0]);
            held_next = {data_byte, held_reg[15:8]};
            if (count_reg != COUNT_MAX)
                count_next = count_reg + 6'd1;

            unique case (count_reg)
                6'd0:  version_next = data_byte;
                6'd1:  node_next    = data_byte;
                6'd2:  fw_next      = {8'd0, data_byte};
                6'd3:  fw_next      = {data_byte, fw_reg[7:0]};
                6'd4:  seq_next     = {8'd0, data_byte};
                6'd5:  seq_next     = {data_byte, seq_reg[7:0]};
                6'd6:  batt_next    = {8'd0, data_byte};
                6'd7:  batt_next    = {data_byte, batt_reg[7:0]};
                6'd8:  chan_next    = {8'd0, data_byte};
                6'd9:  chan_next    = {data_byte, chan_reg[7:0]};
                6'd10: fault_next   = {8'd0, data_byte};
                6'd11:
                begin
                    fault_next  = {data_byte, fault_reg[7:0]};
                    remain_next = chan_reg & LIMIT_MASK;
                end
                default:
                begin
                    // Payload words fill the present channels in ascending order.
                    if (!count_reg[0])
                    begin
                        low_next = data_byte;
                    end
                    else if (remain_reg != 16'd0)
                    begin
                        store_we    = 1'b1;
                        remain_next = remain_reg & (remain_reg - 16'd1);
                    end
                end
            endcase
        end

        if (cmd.restart)
        begin
            count_next = 6'd0;
            crc_next   = CRC_INIT;
            held_next  = 16'd0;
            low_next   = 8'd0;
        end
    end

    always_comb
    begin
        emit_next     = emit_reg;
        o_status_next = o_status_reg;
        o_blank_next  = o_blank_reg;
        o_is_ch_next  = o_is_ch_reg;
        o_idx_next    = o_idx_reg;
        o_value_next  = o_value_reg;
        o_last_next   = o_last_reg;

        if (cmd.load_status)
        begin
            o_status_next = check_status;
            o_blank_next  = (check_status == ST_TOO_SHORT);
            o_is_ch_next  = 1'b0;
            o_idx_next    = 4'd0;
            o_value_next  = 16'd0;
            if (check_status == ST_OK)
            begin
                emit_next   = chan_reg;
                o_last_next = (chan_reg == 16'd0);
            end
            else
            begin
                emit_next   = 16'd0;
                o_last_next = 1'b1;
            end
        end
        else if (cmd.load_next)
        begin
            o_status_next = ST_OK;
            o_blank_next  = 1'b0;
            o_is_ch_next  = 1'b1;
            o_idx_next    = emit_bit;
            o_value_next  = store_reg[emit_bit[IDX_W-1:0]];
            emit_next     = emit_reg & (emit_reg - 16'd1);
            o_last_next   = ((emit_reg & (emit_reg - 16'd1)) == 16'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 6'd0;
            crc_reg    <= CRC_INIT;
            held_reg   <= 16'd0;
            low_reg    <= 8'd0;
            remain_reg <= 16'd0;
            emit_reg   <= 16'd0;
            o_last_reg <= 1'b1;
        end
        else
        begin
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            held_reg   <= held_next;
            low_reg    <= low_next;
            remain_reg <= remain_next;
            emit_reg   <= emit_next;
            o_last_reg <= o_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        version_reg  <= version_next;
        node_reg     <= node_next;
        fw_reg       <= fw_next;
        seq_reg      <= seq_next;
        batt_reg     <= batt_next;
        chan_reg     <= chan_next;
        fault_reg    <= fault_next;
        o_status_reg <= o_status_next;
        o_blank_reg  <= o_blank_next;
        o_is_ch_reg  <= o_is_ch_next;
        o_idx_reg    <= o_idx_next;
        o_value_reg  <= o_value_next;
        if (store_we)
            store_reg[store_waddr] <= {data_byte, low_reg};
    end

    assign stat.more = (emit_reg != 16'd0);
    assign stat.last = o_last_reg;

    // A too-short packet reports blank header fields.
    assign status        = o_status_reg;
    assign node_id       = o_blank_reg ? 8'd0  : node_reg;
    assign firmware_rev  = o_blank_reg ? 16'd0 : fw_reg;
    assign seq           = o_blank_reg ? 16'd0 : seq_reg;
    assign battery_level = o_blank_reg ? 16'd0 : batt_reg;
    assign chan_present  = o_blank_reg ? 16'd0 : chan_reg;
    assign chan_faults   = o_blank_reg ? 16'd0 : fault_reg;
    assign is_channel    = o_is_ch_reg;
    assign channel_index = o_idx_reg;
    assign channel_value = o_value_reg;
    assign last          = o_last_reg;

endmodule

### hdl/sensor_packet_parser_crc16_top.sv
// Top level of the CRC-checked sensor packet parser: config registers and wiring.
//
//  Port   | Kind            | Moves
//  -------+-----------------+------------------------------------------------
//  pkt    | request in      | one packet byte and its end-of-packet flag
//  res    | request out     | status result, then one result per channel on ST_OK
//  apb    | register port   | expected_version (0x0), known_channels (0x4)
//
// Bytes are taken one per cycle while a packet streams in.
// After the end-of-packet byte, the check state runs the checks, then the status
// result and each channel result go out one per cycle while res.ready is high.
// No new byte is taken until the last result of the burst has gone.
// Reset is asynchronous and needs no clearing pass.
`timescale 1ns / 1ps

module sensor_packet_parser_crc16_top
    import sppc_pkg::*;
#(
    parameter int MAX_CHANNELS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    sppc_byte_if.sink     pkt,
    sppc_result_if.source res
);

    logic [7:0]  version_cfg_reg;
    logic [15:0] known_cfg_reg;
    logic        cfg_write;
    sppc_cmd_t   cmd;
    sppc_stat_t  stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_cfg_reg <= 8'd1;
            known_cfg_reg   <= 16'hFFFF;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_EXPECTED_VERSION: version_cfg_reg <= pwdata[7:0];
                REG_KNOWN_CHANNELS:   known_cfg_reg   <= pwdata[15:0];
                default:              known_cfg_reg   <= known_cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_EXPECTED_VERSION: prdata = {24'd0, version_cfg_reg};
            REG_KNOWN_CHANNELS:   prdata = {16'd0, known_cfg_reg};
            default:              prdata = 32'd0;
        endcase
    end

    sppc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pkt.valid),
        .in_eop    (pkt.end_of_packet),
        .in_ready  (pkt.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    sppc_dpath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .data_byte        (pkt.data_byte),
        .expected_version (version_cfg_reg),
        .known_channels   (known_cfg_reg),
        .cmd              (cmd),
        .stat             (stat),
        .status           (res.status),
        .node_id          (res.node_id),
        .firmware_rev     (res.firmware_rev),
        .seq              (res.seq),
        .battery_level    (res.battery_level),
        .chan_present     (res.chan_present),
        .chan_faults      (res.chan_faults),
        .is_channel       (res.is_channel),
        .channel_index    (res.channel_index),
        .channel_value    (res.channel_value),
        .last             (res.last)
    );

endmodule
